/* rtl/sbox_pkg.sv */
// Shared constants for the segment versus box overlap test: register map and field widths.
package sbox_pkg;

   // Width of every coordinate and box bound field on the ports.
   localparam int FIELD_BITS  = 32;
   localparam int FIELD_IDXW  = $clog2(FIELD_BITS);
   // Radius field width (unsigned Q15.16).
   localparam int RADIUS_BITS = 31;
   localparam int NUM_AXES    = 3;

   // Control/status port.
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_IDX_BITS  = 3;

   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   localparam csr_idx_type REG_BOX_MIN_X   = 3'd0;
   localparam csr_idx_type REG_BOX_MAX_X   = 3'd1;
   localparam csr_idx_type REG_BOX_MIN_Y   = 3'd2;
   localparam csr_idx_type REG_BOX_MAX_Y   = 3'd3;
   localparam csr_idx_type REG_BOX_MIN_Z   = 3'd4;
   localparam csr_idx_type REG_BOX_MAX_Z   = 3'd5;
   localparam csr_idx_type REG_GROW_RADIUS = 3'd6;

endpackage

/* rtl/segment_box_overlap_test.sv */
// Top level: pipelined separating-axis test of a segment against a grown box.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------------
//   req     | in        | req_valid/req_ready | start_x/y/z, end_x/y/z (signed Q16.16)
//   rsp     | out       | rsp_valid/rsp_ready | hit (1 = no separating axis)
//   csr     | in/out    | APB, pready tied hi | box bounds x/y/z, grow radius
//
// Throughput is one item per cycle while the rsp side keeps up. There are seven register
// stages from the accepting edge to rsp_valid: input, midpoint/half vector, abs + partial
// products, face test with c*w sums and h*v partials, product differences and h*v sums,
// |lhs| and projected extent, final compare into the output register. The
// 36x36-bit (at COORD_BITS=32) products are split into four half-width partials so no
// single multiplier exceeds about 27x27. Reset clears the valid bits and the CSR registers.
// Each stage moves when the one after it is empty or moving, so bubbles are squeezed
// out and a stalled rsp side holds items in place without loss or repeats.
module segment_box_overlap_test #(
   parameter int COORD_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [sbox_pkg::FIELD_BITS-1:0] req_start_x,
   input  logic signed [sbox_pkg::FIELD_BITS-1:0] req_start_y,
   input  logic signed [sbox_pkg::FIELD_BITS-1:0] req_start_z,
   input  logic signed [sbox_pkg::FIELD_BITS-1:0] req_end_x,
   input  logic signed [sbox_pkg::FIELD_BITS-1:0] req_end_y,
   input  logic signed [sbox_pkg::FIELD_BITS-1:0] req_end_z,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_hit,

   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sbox_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [sbox_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [sbox_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import sbox_pkg::*;

   // Magnitude width: coordinates, or the port field, whichever is wider.
   localparam int MAG = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;
   // Doubled quantities (2c, 2w, 2h) plus headroom.
   localparam int DW  = MAG + 4;
   // Products.
   localparam int PW  = 2 * DW;
   // Operand split for partial products.
   localparam int LW  = (DW + 1) / 2;
   localparam int HW  = DW - LW;
   localparam int SIGN_POS = (COORD_BITS <= FIELD_BITS) ? COORD_BITS - 1 : FIELD_BITS - 1;
   localparam int NSTAGE = 7;

   // Cross-axis operand pairs: (y,z), (x,z), (x,y).
   localparam int PA [NUM_AXES] = '{1, 0, 0};
   localparam int PB [NUM_AXES] = '{2, 2, 1};

   typedef struct packed {
      logic signed [2*HW-1:0]  hh;
      logic signed [HW+LW:0]   hl;
      logic signed [HW+LW:0]   lh;
      logic [2*LW-1:0]         ll;
   } pp_type;

   function automatic logic signed [DW-1:0] coord_ext(input logic [FIELD_BITS-1:0] v);
      logic signed [DW-1:0] r;
      logic                 sgn;
      sgn = (COORD_BITS <= FIELD_BITS) ? v[SIGN_POS] : 1'b0;
      for (int j = 0; j < DW; j++) begin
         r[j] = (j < COORD_BITS && j < FIELD_BITS) ? v[FIELD_IDXW'(j)] : sgn;
      end
      return r;
   endfunction

   function automatic logic signed [DW-1:0] abs_d(input logic signed [DW-1:0] x);
      return x[DW-1] ? -x : x;
   endfunction

   function automatic logic signed [PW-1:0] abs_p(input logic signed [PW-1:0] x);
      return x[PW-1] ? -x : x;
   endfunction

   function automatic pp_type pp_mul(input logic signed [DW-1:0] a,
                                     input logic signed [DW-1:0] b);
      pp_type p;
      p.hh = $signed(a[DW-1:LW]) * $signed(b[DW-1:LW]);
      p.hl = $signed(a[DW-1:LW]) * $signed({1'b0, b[LW-1:0]});
      p.lh = $signed({1'b0, a[LW-1:0]}) * $signed(b[DW-1:LW]);
      p.ll = a[LW-1:0] * b[LW-1:0];
      return p;
   endfunction

   function automatic logic signed [PW-1:0] pp_sum(input pp_type p);
      logic signed [PW-1:0] t_hh;
      logic signed [PW-1:0] t_hl;
      logic signed [PW-1:0] t_lh;
      logic signed [PW-1:0] t_ll;
      t_hh = PW'($signed(p.hh));
      t_hl = PW'($signed(p.hl));
      t_lh = PW'($signed(p.lh));
      t_ll = $signed(PW'(p.ll));
      return (t_hh <<< (2 * LW)) + (t_hl <<< LW) + (t_lh <<< LW) + t_ll;
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers (APB)
   // ------------------------------------------------------------------
   logic [FIELD_BITS-1:0]  bmin_ff [NUM_AXES];
   logic [FIELD_BITS-1:0]  bmax_ff [NUM_AXES];
   logic [RADIUS_BITS-1:0] radius_ff;
   logic                   csr_wr;
   csr_idx_type            csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            bmin_ff[i] <= '0;
            bmax_ff[i] <= '0;
         end
         radius_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_BOX_MIN_X:   bmin_ff[0] <= csr_pwdata;
            REG_BOX_MAX_X:   bmax_ff[0] <= csr_pwdata;
            REG_BOX_MIN_Y:   bmin_ff[1] <= csr_pwdata;
            REG_BOX_MAX_Y:   bmax_ff[1] <= csr_pwdata;
            REG_BOX_MIN_Z:   bmin_ff[2] <= csr_pwdata;
            REG_BOX_MAX_Z:   bmax_ff[2] <= csr_pwdata;
            REG_GROW_RADIUS: radius_ff  <= csr_pwdata[RADIUS_BITS-1:0];
            default: ;  // unmapped index: ignored
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_BOX_MIN_X:   csr_prdata = bmin_ff[0];
         REG_BOX_MAX_X:   csr_prdata = bmax_ff[0];
         REG_BOX_MIN_Y:   csr_prdata = bmin_ff[1];
         REG_BOX_MAX_Y:   csr_prdata = bmax_ff[1];
         REG_BOX_MIN_Z:   csr_prdata = bmin_ff[2];
         REG_BOX_MAX_Z:   csr_prdata = bmax_ff[2];
         REG_GROW_RADIUS: csr_prdata = CSR_DATA_BITS'(radius_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Grown box, doubled: sum = lo + hi (2x center), half = hi - lo (2x half size).
   // Follows the registers in the next cycle; an item reaches stage 1 no earlier than that.
   logic signed [DW-1:0] box_sum_ff  [NUM_AXES];
   logic signed [DW-1:0] box_half_ff [NUM_AXES];
   logic signed [DW-1:0] box_sum_in  [NUM_AXES];
   logic signed [DW-1:0] box_half_in [NUM_AXES];

   always_comb begin
      logic signed [DW-1:0] r;
      logic signed [DW-1:0] lo;
      logic signed [DW-1:0] hi;
      r = $signed(DW'(radius_ff));
      for (int i = 0; i < NUM_AXES; i++) begin
         lo             = coord_ext(bmin_ff[i]) - r;
         hi             = coord_ext(bmax_ff[i]) + r;
         box_sum_in[i]  = lo + hi;
         box_half_in[i] = hi - lo;
      end
   end

   always_ff @(posedge clock) begin
      box_sum_ff  <= box_sum_in;
      box_half_ff <= box_half_in;
   end

   // ------------------------------------------------------------------
   // Pipeline flow control
   // ------------------------------------------------------------------
   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] adv;

   always_comb begin
      adv[NSTAGE-1] = !valid_ff[NSTAGE-1] || rsp_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = adv[0] ? (req_valid && !reset) : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = adv[0] && !reset;
   assign rsp_valid = valid_ff[NSTAGE-1];

   // ------------------------------------------------------------------
   // Stage 0: input item, extended to working width
   // ------------------------------------------------------------------
   logic signed [DW-1:0] st_ff [NUM_AXES];
   logic signed [DW-1:0] en_ff [NUM_AXES];
   logic signed [DW-1:0] st_in [NUM_AXES];
   logic signed [DW-1:0] en_in [NUM_AXES];

   always_comb begin
      st_in[0] = coord_ext(req_start_x);
      st_in[1] = coord_ext(req_start_y);
      st_in[2] = coord_ext(req_start_z);
      en_in[0] = coord_ext(req_end_x);
      en_in[1] = coord_ext(req_end_y);
      en_in[2] = coord_ext(req_end_z);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         st_ff <= st_in;
         en_ff <= en_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: 2c relative to box center, 2w
   // ------------------------------------------------------------------
   logic signed [DW-1:0] c1_ff [NUM_AXES];
   logic signed [DW-1:0] w1_ff [NUM_AXES];
   logic signed [DW-1:0] c1_in [NUM_AXES];
   logic signed [DW-1:0] w1_in [NUM_AXES];

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         c1_in[i] = st_ff[i] + en_ff[i] - box_sum_ff[i];
         w1_in[i] = en_ff[i] - st_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         c1_ff <= c1_in;
         w1_ff <= w1_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: absolute values, partials of the c x w products
   // ------------------------------------------------------------------
   logic signed [DW-1:0] v2_ff    [NUM_AXES];
   logic signed [DW-1:0] ac2_ff   [NUM_AXES];
   pp_type               cwpp2_ff [NUM_AXES][2];
   logic signed [DW-1:0] v2_in    [NUM_AXES];
   logic signed [DW-1:0] ac2_in   [NUM_AXES];
   pp_type               cwpp2_in [NUM_AXES][2];

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         v2_in[i]       = abs_d(w1_ff[i]);
         ac2_in[i]      = abs_d(c1_ff[i]);
         cwpp2_in[i][0] = pp_mul(c1_ff[PA[i]], w1_ff[PB[i]]);
         cwpp2_in[i][1] = pp_mul(c1_ff[PB[i]], w1_ff[PA[i]]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         v2_ff    <= v2_in;
         ac2_ff   <= ac2_in;
         cwpp2_ff <= cwpp2_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: face axes, c x w sums, partials of the h x v products
   // ------------------------------------------------------------------
   logic                 face3_ff;
   logic signed [PW-1:0] cw3_ff   [NUM_AXES][2];
   pp_type               hvpp3_ff [NUM_AXES][2];
   logic                 face3_in;
   logic signed [PW-1:0] cw3_in   [NUM_AXES][2];
   pp_type               hvpp3_in [NUM_AXES][2];

   always_comb begin
      face3_in = 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
         // separates only on a strict gap; touching counts as a hit
         if (ac2_ff[i] > v2_ff[i] + box_half_ff[i]) begin
            face3_in = 1'b1;
         end
         cw3_in[i][0]   = pp_sum(cwpp2_ff[i][0]);
         cw3_in[i][1]   = pp_sum(cwpp2_ff[i][1]);
         hvpp3_in[i][0] = pp_mul(box_half_ff[PA[i]], v2_ff[PB[i]]);
         hvpp3_in[i][1] = pp_mul(box_half_ff[PB[i]], v2_ff[PA[i]]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         face3_ff <= face3_in;
         cw3_ff   <= cw3_in;
         hvpp3_ff <= hvpp3_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: cross product component, h x v sums
   // ------------------------------------------------------------------
   logic                 face4_ff;
   logic signed [PW-1:0] lhs4_ff [NUM_AXES];
   logic signed [PW-1:0] hv4_ff  [NUM_AXES][2];
   logic signed [PW-1:0] lhs4_in [NUM_AXES];
   logic signed [PW-1:0] hv4_in  [NUM_AXES][2];

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         lhs4_in[i]   = cw3_ff[i][0] - cw3_ff[i][1];
         hv4_in[i][0] = pp_sum(hvpp3_ff[i][0]);
         hv4_in[i][1] = pp_sum(hvpp3_ff[i][1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         face4_ff <= face3_ff;
         lhs4_ff  <= lhs4_in;
         hv4_ff   <= hv4_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: |lhs| and projected extent
   // ------------------------------------------------------------------
   logic                 face5_ff;
   logic signed [PW-1:0] alhs5_ff [NUM_AXES];
   logic signed [PW-1:0] rhs5_ff  [NUM_AXES];
   logic signed [PW-1:0] alhs5_in [NUM_AXES];
   logic signed [PW-1:0] rhs5_in  [NUM_AXES];

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         alhs5_in[i] = abs_p(lhs4_ff[i]);
         rhs5_in[i]  = hv4_ff[i][0] + hv4_ff[i][1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         face5_ff <= face4_ff;
         alhs5_ff <= alhs5_in;
         rhs5_ff  <= rhs5_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: output register
   // ------------------------------------------------------------------
   logic hit6_ff;
   logic hit6_in;

   always_comb begin
      logic sep;
      sep = face5_ff;
      for (int i = 0; i < NUM_AXES; i++) begin
         if (rhs5_ff[i] < alhs5_ff[i]) begin
            sep = 1'b1;
         end
      end
      hit6_in = !sep;
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         hit6_ff <= hit6_in;
      end
   end

   assign rsp_hit = hit6_ff;

endmodule

/* tb/segment_hit_check_pkg.sv */
// Segment versus box hit prediction and in-order checking of hit results.
`timescale 1ns / 1ps
package segment_hit_check_pkg;
   import sbox_pkg::*;

   typedef struct packed {
      logic [2:0][FIELD_BITS-1:0] org;
      logic [2:0][FIELD_BITS-1:0] dst;
   } segment_type;

   typedef struct packed {
      segment_type seg;
      logic        hit;
   } hit_expect_type;

   class hit_scoreboard;
      longint         box_lo[3];
      longint         box_hi[3];
      longint         grow;
      hit_expect_type pending_hits[$];
      int             mismatches;
      int             checked;

      function new();
         box_lo = '{0, 0, 0};
         box_hi = '{0, 0, 0};
         grow = 0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void set_reg(csr_idx_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            REG_BOX_MIN_X:   box_lo[0] = longint'($signed(value));
            REG_BOX_MAX_X:   box_hi[0] = longint'($signed(value));
            REG_BOX_MIN_Y:   box_lo[1] = longint'($signed(value));
            REG_BOX_MAX_Y:   box_hi[1] = longint'($signed(value));
            REG_BOX_MIN_Z:   box_lo[2] = longint'($signed(value));
            REG_BOX_MAX_Z:   box_hi[2] = longint'($signed(value));
            REG_GROW_RADIUS: grow = longint'(value[RADIUS_BITS-1:0]);
            default: ;
         endcase
      endfunction

      // Separating-axis test on doubled values: 2c, 2w, 2h. Face axes in 64 bits,
      // cross-product axes in 128 bits, so nothing can wrap.
      function bit segment_meets_box(segment_type seg);
         longint lo, hi, s, e, mag;
         longint c[3], w[3], h[3], v[3];
         logic signed [127:0] ca, cb, wa, wb, ha, hb, va, vb, lhs, rhs;
         int a, b;
         for (int i = 0; i < 3; i++) begin
            lo = box_lo[i] - grow;
            hi = box_hi[i] + grow;
            s = longint'($signed(seg.org[i]));
            e = longint'($signed(seg.dst[i]));
            c[i] = (s + e) - (lo + hi);
            w[i] = e - s;
            h[i] = hi - lo;
            v[i] = (w[i] < 0) ? -w[i] : w[i];
            mag = (c[i] < 0) ? -c[i] : c[i];
            if (mag > v[i] + h[i]) return 1'b0;
         end
         // axis pairs (y,z), (x,z), (x,y)
         for (int k = 0; k < 3; k++) begin
            a = (k == 0) ? 1 : 0;
            b = (k == 2) ? 1 : 2;
            ca = c[a];
            cb = c[b];
            wa = w[a];
            wb = w[b];
            ha = h[a];
            hb = h[b];
            va = v[a];
            vb = v[b];
            lhs = ca * wb - cb * wa;
            if (lhs < 0) lhs = -lhs;
            rhs = ha * vb + hb * va;
            if (rhs < lhs) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_segment(segment_type seg);
         hit_expect_type item;
         item.seg = seg;
         item.hit = segment_meets_box(seg);
         pending_hits.push_back(item);
      endfunction

      function void check_hit(logic hit);
         hit_expect_type want;
         if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("hit result %0b with no item outstanding", hit);
            return;
         end
         want = pending_hits.pop_front();
         if (hit !== want.hit) begin
            mismatches++;
            if (mismatches <= 10)
               $display("hit #%0d: start %h %h %h end %h %h %h expected %0b got %0b",
                        checked, want.seg.org[0], want.seg.org[1], want.seg.org[2],
                        want.seg.dst[0], want.seg.dst[1], want.seg.dst[2], want.hit, hit);
         end
         checked++;
      endfunction

      function int outstanding();
         return pending_hits.size();
      endfunction
   endclass
endpackage

/* tb/tb_segment_box_overlap_test.sv */
// Top of the segment versus box overlap testbench: drivers, stimulus and checking.
`timescale 1ns / 1ps
module tb_segment_box_overlap_test;
   import sbox_pkg::*;
   import segment_hit_check_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transfer of any kind
   localparam int ITEMS_PER_PHASE = 190;
   localparam int TAIL_CYCLES     = 20;
   // index past the last register; writes there must change nothing
   localparam csr_idx_type REG_SPARE = 3'd7;

   typedef enum {PICK_NEAR, PICK_EDGE, PICK_WILD, PICK_RAIL} coord_pick_type;
   typedef enum {BOX_NOMINAL, BOX_RANDOM, BOX_INVERTED, BOX_FULL, BOX_POINT, BOX_WILD}
      box_shape_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [FIELD_BITS-1:0] req_start_x = '0;
   logic [FIELD_BITS-1:0] req_start_y = '0;
   logic [FIELD_BITS-1:0] req_start_z = '0;
   logic [FIELD_BITS-1:0] req_end_x = '0;
   logic [FIELD_BITS-1:0] req_end_y = '0;
   logic [FIELD_BITS-1:0] req_end_z = '0;

   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;

   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   hit_scoreboard sb;

   // sender pacing: counts down a stretch of back-to-back items
   int steady_left = 0;

   // rsp_ready pacing
   int  stall_left = 0;
   int  mode_left = 0;
   bit  choppy = 1'b1;

   box_shape_type plan[7] = '{BOX_NOMINAL, BOX_RANDOM, BOX_INVERTED, BOX_FULL,
                              BOX_POINT, BOX_WILD, BOX_RANDOM};

   always #10 clock = ~clock;

   segment_box_overlap_test i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_start_z (req_start_z),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .req_end_z   (req_end_z),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_hit     (rsp_hit),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Q16.16 from a real, for readable directed items
   function automatic logic [31:0] q(real v);
      return 32'(longint'(v * 65536.0));
   endfunction

   // Mostly zero gaps, some short, a few long; now and then a long burst with none.
   function automatic int next_gap();
      int r;
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         steady_left = $urandom_range(50, 150);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic longint pick_between(longint lo, longint hi);
      longint unsigned span, r;
      span = longint'(hi - lo);
      r = {$urandom, $urandom};
      return lo + longint'(r % (span + 1));
   endfunction

   // One coordinate on an axis, shaped by the box currently loaded.
   function automatic logic [31:0] pick_coord(int axis, coord_pick_type kind);
      longint lo_b, hi_b, span, t;
      logic [31:0] val;
      lo_b = sb.box_lo[axis] - sb.grow;
      hi_b = sb.box_hi[axis] + sb.grow;
      if (hi_b < lo_b) begin
         t = lo_b;
         lo_b = hi_b;
         hi_b = t;
      end
      span = hi_b - lo_b;
      case (kind)
         PICK_NEAR: val = 32'(pick_between(lo_b - span / 4 - 64, hi_b + span / 4 + 64));
         PICK_EDGE: val = 32'((($urandom_range(0, 1) != 0) ? lo_b : hi_b)
                              + longint'(int'($urandom_range(0, 2)) - 1));
         PICK_WILD: val = $urandom;
         default: begin
            case ($urandom_range(0, 3))
               0: val = 32'h8000_0000;
               1: val = 32'h7fff_ffff;
               2: val = 32'h0000_0000;
               default: val = 32'hffff_ffff;
            endcase
         end
      endcase
      return val;
   endfunction

   // Most segments live around the box so all six axes get to decide;
   // the rest are wild values, rail values and single points.
   function automatic segment_type make_segment();
      segment_type seg;
      int mode;
      mode = $urandom_range(0, 99);
      for (int i = 0; i < 3; i++) begin
         if (mode < 45) begin
            seg.org[i] = pick_coord(i, PICK_NEAR);
            seg.dst[i] = pick_coord(i, PICK_NEAR);
         end else if (mode < 65) begin
            seg.org[i] = pick_coord(i, coord_pick_type'($urandom_range(0, 1)));
            seg.dst[i] = pick_coord(i, coord_pick_type'($urandom_range(0, 1)));
         end else if (mode < 80) begin
            seg.org[i] = pick_coord(i, PICK_WILD);
            seg.dst[i] = pick_coord(i, PICK_WILD);
         end else if (mode < 90) begin
            seg.org[i] = pick_coord(i, coord_pick_type'($urandom_range(0, 3)));
            seg.dst[i] = pick_coord(i, coord_pick_type'($urandom_range(0, 3)));
         end else begin
            seg.org[i] = pick_coord(i, coord_pick_type'($urandom_range(0, 1)));
            seg.dst[i] = seg.org[i];
         end
      end
      return seg;
   endfunction

   // Present one item, hold it until taken, then idle for the given gap.
   // Valid is left high when the gap is zero so bursts stay back to back.
   task automatic send_segment(segment_type seg, int gap);
      req_start_x <= seg.org[0];
      req_start_y <= seg.org[1];
      req_start_z <= seg.org[2];
      req_end_x   <= seg.dst[0];
      req_end_y   <= seg.dst[1];
      req_end_z   <= seg.dst[2];
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_segment(seg);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_pair(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
      segment_type seg;
      seg.org = {oz, oy, ox};
      seg.dst = {dz, dy, dx};
      send_segment(seg, next_gap());
   endtask

   // Sender holds off until every hit result is back. Valid is only high here
   // right after an acceptance, so an item is still outstanding and time moves.
   task automatic drain_results();
      if (req_valid) req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Setup cycle then access cycle; the write lands on the access edge.
   // Select is left high so back-to-back writes need no extra cycle.
   task automatic csr_write(csr_idx_type idx, logic [CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   // Full register load. The spare index is written last with junk so any
   // aliasing onto a real register would show up in the hits that follow.
   task automatic load_box(logic [2:0][31:0] lo, logic [2:0][31:0] hi, logic [31:0] radius);
      csr_write(REG_BOX_MIN_X, lo[0]);
      csr_write(REG_BOX_MAX_X, hi[0]);
      csr_write(REG_BOX_MIN_Y, lo[1]);
      csr_write(REG_BOX_MAX_Y, hi[1]);
      csr_write(REG_BOX_MIN_Z, lo[2]);
      csr_write(REG_BOX_MAX_Z, hi[2]);
      // top bit of the radius word is not part of the register
      csr_write(REG_GROW_RADIUS, {1'($urandom_range(0, 1)), radius[RADIUS_BITS-1:0]});
      csr_write(REG_SPARE, $urandom);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic pick_box(box_shape_type shape);
      logic [2:0][31:0] lo, hi;
      logic [31:0] radius, t;
      longint mid, half;
      for (int i = 0; i < 3; i++) begin
         mid  = longint'($urandom_range(0, 32'h0200_0000)) - 64'sh0100_0000;
         half = longint'($urandom_range(0, 32'h0010_0000));
         lo[i] = 32'(mid - half);
         hi[i] = 32'(mid + half);
         case (shape)
            BOX_NOMINAL: begin
               lo[i] = q(-10.0);
               hi[i] = q(10.0);
            end
            BOX_INVERTED: begin
               if (i == 0 || $urandom_range(0, 1) != 0) begin
                  t = lo[i];
                  lo[i] = hi[i];
                  hi[i] = t;
               end
            end
            BOX_POINT: hi[i] = lo[i];
            BOX_FULL: begin
               lo[i] = 32'h8000_0000;
               hi[i] = 32'h7fff_ffff;
            end
            BOX_WILD: begin
               lo[i] = $urandom;
               hi[i] = $urandom;
            end
            default: ;
         endcase
      end
      case (shape)
         BOX_RANDOM, BOX_INVERTED:
            radius = ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom_range(0, 32'h0004_0000);
         BOX_FULL: radius = 32'h7fff_ffff;
         BOX_WILD: radius = $urandom;
         default:  radius = 32'd0;
      endcase
      load_box(lo, hi, radius);
   endtask

   // Result side: rsp_ready stalls start only in choppy stretches, not in clean ones.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         choppy = ($urandom_range(0, 3) != 0);
         mode_left = $urandom_range(40, 300);
      end else begin
         mode_left = mode_left - 1;
      end
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
      end else if (choppy && $urandom_range(0, 3) == 0) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(1, 3);
      end
      rsp_ready <= (stall_left == 0);
   end

   // Every accepted hit result is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_hit(rsp_hit);
   end

   // Watchdog: any transfer on any port counts as progress.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (csr_psel && csr_penable))
            idle = 0;
         else
            idle++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Out of reset the box is a single point at the origin with no growth.
      send_pair(q(-1.0), 32'd0, 32'd0, q(1.0), 32'd0, 32'd0);
      send_pair(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send_pair(q(1.0), q(1.0), q(1.0), q(2.0), q(2.0), q(2.0));
      drain_results();

      // Cube of +-10, no growth.
      load_box({3{q(-10.0)}}, {3{q(10.0)}}, 32'd0);
      send_pair(q(-20.0), 32'd0, 32'd0, q(20.0), 32'd0, 32'd0);          // straight through
      send_pair(q(10.0), 32'd0, 32'd0, q(20.0), 32'd0, 32'd0);           // touches a face
      send_pair(q(10.0) + 32'd1, 32'd0, 32'd0, q(20.0), 32'd0, 32'd0);   // one lsb clear
      send_pair(q(8.5), q(12.5), 32'd0, q(12.5), q(8.5), 32'd0);         // cut off by x*y axis
      send_pair(q(8.0), q(12.0), 32'd0, q(12.0), q(8.0), 32'd0);         // grazes the edge
      send_pair(32'd0, q(8.5), q(12.5), 32'd0, q(12.5), q(8.5));         // cut off, y*z
      send_pair(q(8.5), 32'd0, q(12.5), q(12.5), 32'd0, q(8.5));         // cut off, x*z
      send_pair(q(1.0), q(2.0), q(3.0), q(1.0), q(2.0), q(3.0));         // point inside
      send_pair(q(10.0), q(10.0), q(10.0), q(10.0), q(10.0), q(10.0));   // point on corner
      send_pair(q(10.0), q(10.0), q(10.0) + 32'd1, q(10.0), q(10.0), q(10.0) + 32'd1);
      // field extremes
      send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_pair(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd0, 32'd0);
      drain_results();

      // Same cube grown by 2.5 on every side: edges stay sharp corners.
      load_box({3{q(-10.0)}}, {3{q(10.0)}}, q(2.5));
      send_pair(q(12.0), 32'd0, 32'd0, q(12.0), 32'd0, 32'd0);
      send_pair(q(12.5), 32'd0, 32'd0, q(12.5), 32'd0, 32'd0);
      send_pair(q(12.5) + 32'd1, 32'd0, 32'd0, q(12.5) + 32'd1, 32'd0, 32'd0);
      send_pair(q(11.0), q(14.0), 32'd0, q(14.0), q(11.0), 32'd0);
      send_pair(q(11.25), q(14.25), 32'd0, q(14.25), q(11.25), 32'd0);
      drain_results();

      // Widest possible box with the largest radius.
      load_box({3{32'h8000_0000}}, {3{32'h7fff_ffff}}, 32'h7fff_ffff);
      send_pair(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      drain_results();

      // Fully inverted box, bounds at the rails.
      load_box({3{32'h7fff_ffff}}, {3{32'h8000_0000}}, 32'd0);
      send_pair(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send_pair(32'h8000_0000, 32'd0, 32'd0, 32'h7fff_ffff, 32'd0, 32'd0);
      send_pair(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'd0, 32'hffff_ffff);

      // Random part: one box per phase, box written only while nothing is in flight.
      foreach (plan[p]) begin
         drain_results();
         pick_box(plan[p]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // occasional full hold-off in the middle of a phase
            if ($urandom_range(0, 119) == 0) drain_results();
            send_segment(make_segment(), next_gap());
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
